// File: rtl/ptmt_pkg.sv
// Package for the page table map and translate unit.
// Holds sizes, command and register codes, and the structs shared by the
// table memory, the divider and the top level. No dependencies.
package ptmt_pkg;

    // Table geometry and field widths
    localparam int DEPTH     = 256;
    localparam int SLOT_W    = $clog2(DEPTH);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int ADDR_W    = 32;
    localparam int IDX_W     = 16;
    localparam int ELEM_W    = 16;
    localparam int PAGE_W    = 24;
    localparam int SIZE_W    = 9;
    localparam int PROD_W    = IDX_W + ELEM_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Register reset values
    localparam logic [SIZE_W-1:0] RESET_TABLE_SIZE = SIZE_W'(256);
    localparam logic [PAGE_W-1:0] RESET_PAGE_BYTES = PAGE_W'(4096);
    localparam logic [CNT_W-1:0]  DEPTH_COUNT      = CNT_W'(DEPTH);

    // Command codes
    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_FIND    = 2'd2,
        CMD_CONVERT = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic {
        REG_TABLE_SIZE = 1'b0,
        REG_PAGE_BYTES = 1'b1
    } reg_idx_t;

    // Table memory access request
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [ADDR_W-1:0] wr_data;
    } tbl_req_t;

    // Divider result
    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
        logic [PAGE_W-1:0] remainder;
    } div_res_t;

endpackage

// File: rtl/ptmt_table.sv
// Page base table: one synchronous memory with one read and one write port.
// Per-entry valid bits make the table read as zero after reset.
// Depends on ptmt_pkg.
module ptmt_table
    import ptmt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  tbl_req_t          req,
    output logic [ADDR_W-1:0] rd_data
);

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [ADDR_W-1:0] rd_data_reg;

    // Write the entry; a zero word marks the slot empty
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Track which entries hold a written word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= (req.wr_data != '0);
        end
    end

    // Registered read; entries never written read as zero
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/ptmt_div.sv
// Restoring divider, one quotient bit per cycle, for the convert path.
// Splits a byte offset into page number and offset within the page.
// Depends on ptmt_pkg.
module ptmt_div
    import ptmt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [PAGE_W-1:0] divisor,
    output div_res_t          res
);

    logic [PROD_W-1:0]    quo_reg, quo_next;
    logic [PAGE_W-1:0]    rem_reg, rem_next;
    logic [PAGE_W-1:0]    divisor_reg;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [PAGE_W:0]      trial;
    logic                 ge;

    // One shift-subtract step
    always_comb begin
        trial      = {rem_reg, quo_reg[PROD_W-1]};
        ge         = (trial >= {1'b0, divisor_reg});
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            rem_next   = '0;
            quo_next   = dividend;
            count_next = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            rem_next   = ge ? PAGE_W'(trial - {1'b0, divisor_reg}) : trial[PAGE_W-1:0];
            quo_next   = {quo_reg[PROD_W-2:0], ge};
            count_next = count_reg + 1'b1;
            if (count_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Datapath holds the last result until the next start
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            divisor_reg <= divisor;
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

// File: rtl/page_table_map_translate_unit.sv
// Page table map and translate unit: insert, remove, find and convert.
// Insert, remove, find: the accepted word goes through S_READ and S_EXEC to the result word.
// Convert: the accepted word goes through S_MUL, S_DIV_GO, S_DIV_WAIT, S_READ and S_EXEC,
// with the 32-step divider for offset / page. A stalled result word adds its stall.
// One word is in work at a time; the next word is taken while a result waits.
// Reset (aresetn, synchronous, active low) empties the table at once through
// per-entry valid bits, clears the count and loads size 256, page 4096.
module page_table_map_translate_unit
    import ptmt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [PAGE_W-1:0] cfg_data,
    // Command channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_command,
    input  logic [IDX_W-1:0]  s_index,
    input  logic [ADDR_W-1:0] s_base_address,
    input  logic [ELEM_W-1:0] s_element_bytes,
    // Result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_ok,
    output logic [ADDR_W-1:0] m_address,
    output logic [CNT_W-1:0]  m_used_count,
    output logic              m_empty_res,
    output logic              m_full_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_READ,
        S_EXEC
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] table_size_reg, table_size_next;
    logic [PAGE_W-1:0] page_bytes_reg, page_bytes_next;
    logic [CNT_W-1:0]  occupied_reg, occupied_next;
    cmd_t              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ELEM_W-1:0] elem_reg, elem_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [PAGE_W-1:0] rem_reg, rem_next;
    logic              hit_reg, hit_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_ok_reg, m_ok_next;
    logic [ADDR_W-1:0] m_address_reg, m_address_next;
    logic [CNT_W-1:0]  m_used_reg, m_used_next;
    logic              m_empty_reg, m_empty_next;
    logic              m_full_reg, m_full_next;

    logic [CNT_W-1:0]  eff_size;
    logic [PAGE_W-1:0] page_eff;
    logic              out_free;
    logic [ADDR_W-1:0] rd_data;
    tbl_req_t          tbl_req;
    div_res_t          div_res;
    logic              div_start;

    // Effective table size clamped to [1, DEPTH] and effective page size
    always_comb begin
        if (table_size_reg == '0) begin
            eff_size = CNT_W'(1);
        end else if (CNT_W'(table_size_reg) > DEPTH_COUNT) begin
            eff_size = DEPTH_COUNT;
        end else begin
            eff_size = CNT_W'(table_size_reg);
        end
        page_eff = (page_bytes_reg != '0) ? page_bytes_reg : PAGE_W'(eff_size);
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign div_start = (state_reg == S_DIV_GO);

    // Sequencer and config writes: read the slot, modify, write back, load the result word
    always_comb begin
        state_next      = state_reg;
        table_size_next = table_size_reg;
        page_bytes_next = page_bytes_reg;
        occupied_next   = occupied_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        base_next       = base_reg;
        elem_next       = elem_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_ok_next       = m_ok_reg;
        m_address_next  = m_address_reg;
        m_used_next     = m_used_reg;
        m_empty_next    = m_empty_reg;
        m_full_next     = m_full_reg;
        tbl_req         = '0;

        // Configuration writes
        if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_TABLE_SIZE: table_size_next = cfg_data[SIZE_W-1:0];
                REG_PAGE_BYTES: page_bytes_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = cmd_t'(s_command);
                    idx_next   = s_index;
                    base_next  = s_base_address;
                    elem_next  = s_element_bytes;
                    slot_next  = s_index[SLOT_W-1:0];
                    hit_next   = (s_index < IDX_W'(eff_size));
                    rem_next   = '0;
                    state_next = (cmd_t'(s_command) == CMD_CONVERT) ? S_MUL : S_READ;
                end
            end
            S_MUL: begin
                prod_next  = PROD_W'(idx_reg) * PROD_W'(elem_reg);
                state_next = S_DIV_GO;
            end
            S_DIV_GO: begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_res.done) begin
                    hit_next   = (div_res.quotient < PROD_W'(eff_size));
                    slot_next  = div_res.quotient[SLOT_W-1:0];
                    rem_next   = div_res.remainder;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = slot_reg;
                state_next      = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    m_ok_next      = 1'b0;
                    m_address_next = '0;
                    case (cmd_reg)
                        CMD_INSERT: begin
                            if (occupied_reg < eff_size && hit_reg && base_reg != '0
                                && rd_data == '0) begin
                                tbl_req.wr_en   = 1'b1;
                                tbl_req.wr_addr = slot_reg;
                                tbl_req.wr_data = base_reg;
                                occupied_next   = occupied_reg + 1'b1;
                                m_ok_next       = 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            if (occupied_reg != '0 && hit_reg && rd_data != '0) begin
                                tbl_req.wr_en   = 1'b1;
                                tbl_req.wr_addr = slot_reg;
                                tbl_req.wr_data = '0;
                                occupied_next   = occupied_reg - 1'b1;
                                m_ok_next       = 1'b1;
                                m_address_next  = rd_data;
                            end
                        end
                        CMD_FIND: begin
                            if (hit_reg) begin
                                m_ok_next      = 1'b1;
                                m_address_next = rd_data;
                            end
                        end
                        default: begin
                            if (hit_reg) begin
                                m_ok_next      = 1'b1;
                                m_address_next = rd_data + ADDR_W'(rem_reg);
                            end
                        end
                    endcase
                    m_valid_next = 1'b1;
                    m_used_next  = occupied_next;
                    m_empty_next = (occupied_next == '0);
                    m_full_next  = (occupied_next == eff_size);
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            table_size_reg <= RESET_TABLE_SIZE;
            page_bytes_reg <= RESET_PAGE_BYTES;
            occupied_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            table_size_reg <= table_size_next;
            page_bytes_reg <= page_bytes_next;
            occupied_reg   <= occupied_next;
            m_valid_reg    <= m_valid_next;
        end
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        base_reg      <= base_next;
        elem_reg      <= elem_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        hit_reg       <= hit_next;
        slot_reg      <= slot_next;
        m_ok_reg      <= m_ok_next;
        m_address_reg <= m_address_next;
        m_used_reg    <= m_used_next;
        m_empty_reg   <= m_empty_next;
        m_full_reg    <= m_full_next;
    end

    ptmt_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rd_data (rd_data)
    );

    ptmt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (page_eff),
        .res      (div_res)
    );

    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_address    = m_address_reg;
    assign m_used_count = m_used_reg;
    assign m_empty_res  = m_empty_reg;
    assign m_full_res   = m_full_reg;

endmodule

// File: rtl/ptmt_checker.sv
// Port-level checks for the page table map and translate unit.
// Bound to page_table_map_translate_unit; depends on ptmt_pkg.
module ptmt_checker
    import ptmt_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_ok,
    input logic [ADDR_W-1:0] m_address,
    input logic [CNT_W-1:0]  m_used_count,
    input logic              m_empty_res
);

    // Hold a stalled result word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_address) && $stable(m_ok))
        else $error("result word changed while stalled");

    // A refused or out-of-range word returns no address
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_address == '0)
        else $error("address not zero on failed word");

    // Empty flag follows the count
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_empty_res == (m_used_count == '0))
        else $error("empty flag disagrees with count");

    // Count never exceeds the table depth
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_used_count <= DEPTH_COUNT)
        else $error("used count above depth");

endmodule

bind page_table_map_translate_unit ptmt_checker u_ptmt_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_ok         (m_ok),
    .m_address    (m_address),
    .m_used_count (m_used_count),
    .m_empty_res  (m_empty_res)
);

// File: bench/tb_page_table_map_translate_unit.sv
// Self-checking bench for page_table_map_translate_unit: directed and random
// insert/remove/find/convert words under several table and page settings.
// Depends on ptmt_pkg and the unit RTL only.
module tb_page_table_map_translate_unit;
    import ptmt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct {
        logic              ok;
        logic [ADDR_W-1:0] address;
        logic [CNT_W-1:0]  used_count;
        logic              empty_res;
        logic              full_res;
    } xlate_result_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [PAGE_W-1:0] cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_command;
    logic [IDX_W-1:0]  s_index;
    logic [ADDR_W-1:0] s_base_address;
    logic [ELEM_W-1:0] s_element_bytes;
    logic              m_valid;
    logic              m_ready;
    logic              m_ok;
    logic [ADDR_W-1:0] m_address;
    logic [CNT_W-1:0]  m_used_count;
    logic              m_empty_res;
    logic              m_full_res;

    // Shadow copy of the table, its count and its registers
    logic [ADDR_W-1:0] slot_base [DEPTH];
    int                used_slots;
    logic [SIZE_W-1:0] size_reg;
    logic [PAGE_W-1:0] page_reg;

    xlate_result_t     pending_results[$];
    int                error_count;
    int                idle_cycles;
    int                send_quiet_left;

    page_table_map_translate_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_index         (s_index),
        .s_base_address  (s_base_address),
        .s_element_bytes (s_element_bytes),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_address       (m_address),
        .m_used_count    (m_used_count),
        .m_empty_res     (m_empty_res),
        .m_full_res      (m_full_res)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Effective table size: zero reads as one, above DEPTH saturates
    function automatic int live_size();
        int sz;
        sz = int'(size_reg);
        if (sz == 0) sz = 1;
        if (sz > DEPTH) sz = DEPTH;
        return sz;
    endfunction

    function automatic longint live_page();
        if (page_reg != '0) return longint'(page_reg);
        return longint'(live_size());
    endfunction

    // Apply one command word to the shadow table and return its result word
    function automatic xlate_result_t translate_command(cmd_t cmd, logic [IDX_W-1:0] idx,
                                                        logic [ADDR_W-1:0] base,
                                                        logic [ELEM_W-1:0] elem);
        xlate_result_t res;
        int            sz;
        longint        pg;
        longint        offset;
        longint        slot;
        sz = live_size();
        res.ok = 1'b0;
        res.address = '0;
        case (cmd)
            CMD_INSERT: begin
                if (used_slots < sz && int'(idx) < sz && base != '0
                    && slot_base[SLOT_W'(idx)] == '0) begin
                    slot_base[SLOT_W'(idx)] = base;
                    used_slots++;
                    res.ok = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (used_slots != 0 && int'(idx) < sz && slot_base[SLOT_W'(idx)] != '0) begin
                    res.address = slot_base[SLOT_W'(idx)];
                    slot_base[SLOT_W'(idx)] = '0;
                    used_slots--;
                    res.ok = 1'b1;
                end
            end
            CMD_FIND: begin
                if (int'(idx) < sz) begin
                    res.address = slot_base[SLOT_W'(idx)];
                    res.ok = 1'b1;
                end
            end
            default: begin
                pg = live_page();
                offset = longint'(idx) * longint'(elem);
                slot = offset / pg;
                if (slot < sz) begin
                    res.address = ADDR_W'(longint'(slot_base[SLOT_W'(slot)]) + offset % pg);
                    res.ok = 1'b1;
                end
            end
        endcase
        res.used_count = CNT_W'(used_slots);
        res.empty_res = (used_slots == 0);
        res.full_res = (used_slots == sz);
        return res;
    endfunction

    task automatic check_field(string name, logic [ADDR_W-1:0] exp_val,
                               logic [ADDR_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Track accepted words: predict on command and config, compare on result
    always @(posedge aclk) begin
        xlate_result_t exp_res;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (reg_idx_t'(cfg_index) == REG_TABLE_SIZE) size_reg = cfg_data[SIZE_W-1:0];
                else page_reg = cfg_data;
            end
            if (s_valid && s_ready)
                pending_results.push_back(translate_command(cmd_t'(s_command), s_index,
                                                            s_base_address, s_element_bytes));
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result word with nothing expected, address %h",
                             $time, m_address);
                    error_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    check_field("ok", ADDR_W'(exp_res.ok), ADDR_W'(m_ok));
                    check_field("address", exp_res.address, m_address);
                    check_field("used_count", ADDR_W'(exp_res.used_count),
                                ADDR_W'(m_used_count));
                    check_field("empty_res", ADDR_W'(exp_res.empty_res), ADDR_W'(m_empty_res));
                    check_field("full_res", ADDR_W'(exp_res.full_res), ADDR_W'(m_full_res));
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Result side backpressure: runs of ready, mostly short stalls, a few long
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 120)) @(posedge aclk);
            else repeat ($urandom_range(1, 6)) @(posedge aclk);
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 3);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Sender gap: quiet stretches with no gaps, otherwise mostly short gaps
    function automatic int next_send_gap();
        int r;
        if (send_quiet_left > 0) begin
            send_quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            send_quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one command word; returns at the edge where it is accepted
    task automatic send_command(cmd_t cmd, logic [IDX_W-1:0] idx, logic [ADDR_W-1:0] base,
                                logic [ELEM_W-1:0] elem);
        int gap;
        gap = next_send_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_index         <= idx;
        s_base_address  <= base;
        s_element_bytes <= elem;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and hold until every expected result word is back
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Register write; only called while the unit is idle
    task automatic write_reg(reg_idx_t which, logic [PAGE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Random words: mostly in-range slots, convert offsets aimed inside the table
    task automatic send_random_items(int count);
        int                r;
        int                sz;
        cmd_t              cmd;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] base;
        logic [ELEM_W-1:0] elem;
        longint            span;
        longint            lim;
        for (int n = 0; n < count; n++) begin
            sz = live_size();
            r = $urandom_range(0, 99);
            if (r < 35) cmd = CMD_INSERT;
            else if (r < 55) cmd = CMD_REMOVE;
            else if (r < 70) cmd = CMD_FIND;
            else cmd = CMD_CONVERT;
            r = $urandom_range(0, 99);
            if (r < 80) idx = IDX_W'($urandom_range(0, sz - 1));
            else if (r < 90) idx = IDX_W'($urandom_range(sz, sz + 3));
            else idx = IDX_W'($urandom);
            base = ($urandom_range(0, 9) == 0) ? '0 : ADDR_W'($urandom);
            elem = ELEM_W'($urandom);
            if (cmd == CMD_CONVERT && $urandom_range(0, 9) < 7) begin
                span = live_page() * longint'(sz);
                elem = ($urandom_range(0, 1) == 0) ? ELEM_W'($urandom_range(1, 16))
                                                   : ELEM_W'($urandom_range(1, 65535));
                lim = (span - 1) / longint'(elem);
                if (lim > 65535) lim = 65535;
                idx = IDX_W'($urandom_range(0, int'(lim)));
            end
            send_command(cmd, idx, base, elem);
        end
        wait_idle();
    endtask

    // Default registers: every command, empty and occupied slots, edges of ranges
    task automatic test_directed();
        send_command(CMD_FIND, 16'd0, 32'd0, 16'd0);
        send_command(CMD_REMOVE, 16'd0, 32'd0, 16'd0);
        send_command(CMD_INSERT, 16'd0, 32'hFFFF_FFFF, 16'd0);
        send_command(CMD_INSERT, 16'd255, 32'd1, 16'd0);
        send_command(CMD_INSERT, 16'd0, 32'h1234_5678, 16'd0);
        send_command(CMD_INSERT, 16'd5, 32'd0, 16'd0);
        send_command(CMD_INSERT, 16'd256, 32'hA5A5_A5A5, 16'd0);
        send_command(CMD_INSERT, 16'hFFFF, 32'h5A5A_5A5A, 16'hFFFF);
        send_command(CMD_FIND, 16'd0, 32'd0, 16'd0);
        send_command(CMD_FIND, 16'd255, 32'd0, 16'd0);
        send_command(CMD_FIND, 16'hFFFF, 32'd0, 16'd0);
        send_command(CMD_REMOVE, 16'd7, 32'd0, 16'd0);
        send_command(CMD_CONVERT, 16'd0, 32'd0, 16'd0);
        send_command(CMD_CONVERT, 16'hFFFF, 32'd0, 16'hFFFF);
        send_command(CMD_CONVERT, 16'd1, 32'd0, 16'd4095);
        send_command(CMD_CONVERT, 16'd255, 32'd0, 16'd4096);
        send_command(CMD_CONVERT, 16'd3, 32'd0, 16'd4096);
        send_command(CMD_CONVERT, 16'd256, 32'd0, 16'd4096);
        send_command(CMD_REMOVE, 16'd0, 32'd0, 16'd0);
        send_command(CMD_REMOVE, 16'd255, 32'd0, 16'd0);
        send_command(CMD_REMOVE, 16'hFFFF, 32'd0, 16'd0);
        wait_idle();
    endtask

    // Size zero reads as one; page zero follows the table size
    task automatic test_tiny_table();
        write_reg(REG_TABLE_SIZE, '0);
        write_reg(REG_PAGE_BYTES, '0);
        send_random_items(30);
        write_reg(REG_TABLE_SIZE, PAGE_W'(1));
        write_reg(REG_PAGE_BYTES, PAGE_W'(1));
        send_random_items(30);
    endtask

    // Fill a small table, then oversize, then shrink below the occupied count
    task automatic test_fill_and_shrink();
        write_reg(REG_TABLE_SIZE, PAGE_W'(4));
        write_reg(REG_PAGE_BYTES, PAGE_W'(16));
        send_random_items(80);
        write_reg(REG_TABLE_SIZE, PAGE_W'(511));
        write_reg(REG_PAGE_BYTES, '0);
        send_random_items(70);
        write_reg(REG_TABLE_SIZE, PAGE_W'(3));
        send_random_items(40);
    endtask

    // Random sizes and pages, including the largest page
    task automatic test_random_geometry();
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(REG_TABLE_SIZE, PAGE_W'($urandom_range(1, 300)));
            case (phase)
                0: write_reg(REG_PAGE_BYTES, PAGE_W'(24'hFF_FFFF));
                1: write_reg(REG_PAGE_BYTES, PAGE_W'($urandom_range(1, 64)));
                2: write_reg(REG_PAGE_BYTES, PAGE_W'(4096));
                default: write_reg(REG_PAGE_BYTES, PAGE_W'($urandom));
            endcase
            send_random_items(40);
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = 1'b0;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_command       = '0;
        s_index         = '0;
        s_base_address  = '0;
        s_element_bytes = '0;
        error_count     = 0;
        idle_cycles     = 0;
        send_quiet_left = 0;
        used_slots      = 0;
        size_reg        = RESET_TABLE_SIZE;
        page_reg        = RESET_PAGE_BYTES;
        for (int i = 0; i < DEPTH; i++) slot_base[SLOT_W'(i)] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_tiny_table();
        test_fill_and_shrink();
        test_random_geometry();

        // Let any stray result word show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
